[rtl/core/cordic_sine_cosine_q31_assert.svh]
// Assertion macros used by the sine and cosine checker file.
`ifndef CORDIC_SINE_COSINE_Q31_ASSERT_SVH
`define CORDIC_SINE_COSINE_Q31_ASSERT_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define CSC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("csc assertion failed");

// Next-cycle implication, checked on every clock edge out of reset.
`define CSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("csc assertion failed");

`endif

[rtl/core/csc_pkg.sv]
// Package with types, constants and the arctangent table for the CORDIC sine and cosine block.
package csc_pkg;

  localparam int unsigned IterationsDef = 31;
  localparam int unsigned MaxIterations = 31;

  localparam int unsigned PhaseW = 32;
  localparam int unsigned ValueW = 32;
  localparam int unsigned XW     = 34;
  localparam int unsigned ZW     = 33;
  localparam int unsigned AtanW  = 30;

  localparam logic [PhaseW-1:0] Quarter   = 32'h4000_0000;
  localparam logic [XW-1:0]     GainStart = 34'd1304065748;
  localparam logic [ValueW-1:0] Q31Max    = 32'h7fff_ffff;

  localparam logic [AtanW-1:0] AtanTable [MaxIterations] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1
  };

  typedef struct packed {
    logic                 special;
    logic                 zero;
    logic                 negate;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } csc_item_t;

endpackage

[rtl/core/csc_fold.sv]
// Input stage: cosine offset, quadrant fold and CORDIC start values.
module csc_fold (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic                      op_i,
  input  logic [csc_pkg::PhaseW-1:0] phase_i,
  output logic                      valid_o,
  output csc_pkg::csc_item_t        item_o
);
  import csc_pkg::*;

  logic [PhaseW-1:0] ang;
  logic [AtanW:0]    zmag;
  csc_item_t         item_d, item_q;
  logic              valid_q;

  always_comb begin
    ang  = phase_i + (op_i ? Quarter : '0);
    zmag = ang[30] ? ((AtanW+1)'(1) << AtanW) - {1'b0, ang[AtanW-1:0]}
                   : {1'b0, ang[AtanW-1:0]};
    item_d.special = (ang[AtanW-1:0] == '0);
    item_d.zero    = !ang[30];
    item_d.negate  = ang[31];
    item_d.x       = GainStart;
    item_d.y       = '0;
    item_d.z       = ZW'(zmag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[rtl/core/csc_stage.sv]
// One rotation-mode CORDIC iteration with its pipeline register.
module csc_stage #(
  parameter int unsigned Idx = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  csc_pkg::csc_item_t item_i,
  output logic               valid_o,
  output csc_pkg::csc_item_t item_o
);
  import csc_pkg::*;

  localparam logic [XW-1:0] Round = (XW'(1) << Idx) - XW'(1);
  localparam logic signed [ZW-1:0] Atan = ZW'(AtanTable[Idx]);

  logic signed [XW-1:0] xs, ys;
  csc_item_t            item_d, item_q;
  logic                 valid_q;

  always_comb begin
    xs = $signed(item_i.x + (item_i.x[XW-1] ? Round : '0)) >>> Idx;
    ys = $signed(item_i.y + (item_i.y[XW-1] ? Round : '0)) >>> Idx;
    item_d = item_i;
    if (!item_i.z[ZW-1]) begin
      item_d.x = item_i.x - ys;
      item_d.y = item_i.y + xs;
      item_d.z = item_i.z - Atan;
    end else begin
      item_d.x = item_i.x + ys;
      item_d.y = item_i.y - xs;
      item_d.z = item_i.z + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[rtl/core/cordic_sine_cosine_q31.sv]
// Top level of the pipelined CORDIC sine and cosine unit in Q31.
//
// Input channel: in_valid_i, in_ready_o, op_i (0 sine, 1 cosine) and phase_i,
// an unsigned angle with 2^32 counts per turn.
// Output channel: out_valid_o, out_ready_i and value_o, signed Q31 limited
// to plus or minus (2^31 - 1).
// Every accepted item yields exactly one result item, in order.
// Each item passes through one fold stage, one stage per CORDIC
// iteration and one output register. Unless the receiver stalls,
// throughput is one item per cycle, since each stage holds a single iteration.
// Reset clears all valid bits, so the pipeline comes up empty.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready_o drops; nothing is lost or repeated. While the output
// register is empty or being taken, in_ready_o stays high.
module cordic_sine_cosine_q31 #(
  parameter int unsigned ITERATIONS = csc_pkg::IterationsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       op_i,
  input  logic [csc_pkg::PhaseW-1:0] phase_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [csc_pkg::ValueW-1:0] value_o
);
  import csc_pkg::*;

  localparam logic signed [XW-1:0] SatHi = XW'(Q31Max);
  localparam logic signed [XW-1:0] SatLo = -SatHi;

  logic                 en;
  logic                 pipe_valid [ITERATIONS+1];
  csc_item_t            pipe_item  [ITERATIONS+1];
  csc_item_t            last;
  logic signed [XW-1:0] ysign;
  logic [ValueW-1:0]    value_d, value_q;
  logic                 out_valid_q;

  assign en = !out_valid_q || out_ready_i;

  csc_fold u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .op_i    (op_i),
    .phase_i (phase_i),
    .valid_o (pipe_valid[0]),
    .item_o  (pipe_item[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_stage
    csc_stage #(.Idx(i)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (pipe_valid[i]),
      .item_i  (pipe_item[i]),
      .valid_o (pipe_valid[i+1]),
      .item_o  (pipe_item[i+1])
    );
  end

  always_comb begin
    last  = pipe_item[ITERATIONS];
    ysign = last.negate ? -last.y : last.y;
    if (last.special) begin
      value_d = last.zero ? '0 : (last.negate ? -Q31Max : Q31Max);
    end else if (ysign > SatHi) begin
      value_d = Q31Max;
    end else if (ysign < SatLo) begin
      value_d = -Q31Max;
    end else begin
      value_d = ValueW'(ysign);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= pipe_valid[ITERATIONS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      value_q <= value_d;
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

endmodule

[rtl/core/csc_checker.sv]
// Port-level checker for the CORDIC sine and cosine unit, with its bind.
`include "cordic_sine_cosine_q31_assert.svh"

module csc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [csc_pkg::ValueW-1:0] value_o
);
  import csc_pkg::*;

  `CSC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(value_o))
  `CSC_ASSERT_NOW(a_no_min_value, out_valid_o, value_o != ~Q31Max)
  `CSC_ASSERT_NOW(a_ready_when_empty, !out_valid_o, in_ready_o)
  `CSC_ASSERT_NOW(a_ready_when_taken, out_valid_o && out_ready_i, in_ready_o)
  `CSC_ASSERT_NEXT(a_stall_holds_input, in_valid_i && !in_ready_o, out_valid_o)

endmodule

bind cordic_sine_cosine_q31 csc_checker u_csc_checker (.*);
